### sv/ccm_pkg.sv
`default_nettype none

package ccm_pkg;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_AAD   = 2'd1,
		MODE_PL    = 2'd2,
		MODE_TAG   = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_TAG     = 2'd1,
		KIND_STATUS  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		CFG_KEY0      = 3'd0,
		CFG_KEY1      = 3'd1,
		CFG_KEY2      = 3'd2,
		CFG_KEY3      = 3'd3,
		CFG_KEY_SIZE  = 3'd4,
		CFG_TAG_SIZE  = 3'd5,
		CFG_DIRECTION = 3'd6,
		CFG_VERIFY    = 3'd7
	} cfg_idx_t;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_AAD     = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_TAG     = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KEYX,
		ST_B0,
		ST_A0,
		ST_AAD_CHK,
		ST_AAD_BLK,
		ST_AAD_END,
		ST_AAD_TAIL,
		ST_ENTER,
		ST_CTR,
		ST_PGO,
		ST_PMAC,
		ST_OUT_CHUNK,
		ST_OUT_TAG,
		ST_OUT_STAT
	} state_t;

	typedef enum logic [2:0] {
		SRC_B0,
		SRC_A0,
		SRC_AAD,
		SRC_TAIL,
		SRC_CTR,
		SRC_PMAC
	} aes_src_t;

	typedef enum logic [1:0] {
		DST_NONE,
		DST_MAC,
		DST_MASK,
		DST_CTR
	} aes_dst_t;

	typedef enum logic [1:0] {
		OSEL_NONE,
		OSEL_CHUNK,
		OSEL_TAG,
		OSEL_STAT
	} out_sel_t;

	typedef struct packed {
		logic     start_msg;
		logic     latch_aad;
		logic     latch_pl;
		logic     kx_step;
		logic     aes_go;
		aes_src_t aes_src;
		aes_dst_t aes_dst;
		logic     clr_buf;
		out_sel_t out_sel;
	} cmd_t;

	typedef struct packed {
		logic kx_done;
		logic aes_done;
		logic aad_in_zero;
		logic pl_in_zero;
		logic aad_full;
		logic aad_left_zero;
		logic fill_zero;
		logic pl_left_zero;
		logic decrypt;
	} sts_t;

	localparam logic [31:0] AAD_SHORT_LIMIT = 32'h0000_ff00;
	localparam logic [15:0] AAD_LONG_MARK   = 16'hfffe;
	localparam logic [7:0]  CTR_FLAGS       = 8'h02;
	localparam logic [7:0]  B0_ADATA_FLAG   = 8'h40;
	localparam logic [3:0]  NR_AES128       = 4'd10;
	localparam logic [3:0]  NR_AES256       = 4'd14;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] rcon(input logic [3:0] idx);
		logic [7:0] r;
		unique case (idx)
			4'd1:    r = 8'h01;
			4'd2:    r = 8'h02;
			4'd3:    r = 8'h04;
			4'd4:    r = 8'h08;
			4'd5:    r = 8'h10;
			4'd6:    r = 8'h20;
			4'd7:    r = 8'h40;
			4'd8:    r = 8'h80;
			4'd9:    r = 8'h1b;
			4'd10:   r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	// Mask that keeps the first n bytes of a big-endian 16-byte block.
	function automatic logic [127:0] byte_mask(input logic [4:0] n);
		logic [127:0] m;
		m = '0;
		for (int i = 0; i < 16; i++) begin
			if (5'(i) < n) begin
				m[127 - 8 * i -: 8] = 8'hff;
			end
		end
		return m;
	endfunction

	// One AES round without the round key: SubBytes, ShiftRows and, except in
	// the final round, MixColumns.
	function automatic logic [127:0] aes_round(input logic [127:0] s, input logic fin);
		logic [7:0] b [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3, al;
		logic [127:0] r;
		for (int i = 0; i < 16; i++) begin
			b[i] = s[127 - 8 * i -: 8];
		end
		for (int c = 0; c < 4; c++) begin
			for (int i = 0; i < 4; i++) begin
				t[c * 4 + i] = SBOX[b[((c + i) & 3) * 4 + i]];
			end
		end
		if (!fin) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[c * 4];
				a1 = t[c * 4 + 1];
				a2 = t[c * 4 + 2];
				a3 = t[c * 4 + 3];
				al = a0 ^ a1 ^ a2 ^ a3;
				t[c * 4]     = a0 ^ al ^ xt(a0 ^ a1);
				t[c * 4 + 1] = a1 ^ al ^ xt(a1 ^ a2);
				t[c * 4 + 2] = a2 ^ al ^ xt(a2 ^ a3);
				t[c * 4 + 3] = a3 ^ al ^ xt(a3 ^ a0);
			end
		end
		for (int i = 0; i < 16; i++) begin
			r[127 - 8 * i -: 8] = t[i];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### sv/ccm_aes_core.sv
`default_nettype none

// Iterative AES encryption, one round per cycle.
module ccm_aes_core
	import ccm_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         go,
	input  wire logic [127:0] din,
	input  wire logic [3:0]   nr,
	input  wire logic [127:0] rk,
	output logic      [3:0]   rk_idx,
	output logic              done,
	output logic      [127:0] dout
);

	logic [127:0] st_q;
	logic [3:0]   rnd_q;
	logic         busy_q;
	logic         done_q;

	assign rk_idx = go ? 4'd0 : rnd_q;
	assign done   = done_q;
	assign dout   = st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rnd_q  <= 4'd0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (go) begin
			rnd_q  <= 4'd1;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (rnd_q == nr) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				rnd_q <= rnd_q + 4'd1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			st_q <= din ^ rk;
		end else if (busy_q) begin
			st_q <= aes_round(st_q, rnd_q == nr) ^ rk;
		end
	end

endmodule

`default_nettype wire

### sv/ccm_datapath.sv
`default_nettype none

// Key registers, key schedule, CCM chaining values, AAD realignment and the
// result register.
module ccm_datapath
	import ccm_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire cmd_t         cmd,
	output sts_t              sts,
	input  wire logic         cfg_we,
	input  wire logic [2:0]   cfg_index,
	input  wire logic [63:0]  cfg_data,
	input  wire logic [63:0]  nonce_high,
	input  wire logic [31:0]  nonce_low,
	input  wire logic [23:0]  payload_length,
	input  wire logic [31:0]  aad_length,
	input  wire logic [63:0]  block_high,
	input  wire logic [63:0]  block_low,
	input  wire logic [4:0]   valid_bytes,
	output logic      [1:0]   result_kind,
	output logic      [63:0]  out_high,
	output logic      [63:0]  out_low,
	output logic      [4:0]   out_valid_bytes,
	output logic              auth_ok,
	output logic              last
);

	logic [63:0]  key0_q, key1_q, key2_q, key3_q;
	logic         key_size_q, tag_size_q, dir_q, verify_q;

	logic [127:0] rk_q [15];
	logic [255:0] win_q;
	logic [3:0]   kx_idx_q;
	logic [3:0]   nr_q;
	logic         nk8_q;

	logic [127:0] mac_q, mask_q, buf_q, blk_q, res_q;
	logic [95:0]  nonce_q;
	logic [23:0]  ctr_q, pl_left_q;
	logic [31:0]  aad_left_q;
	logic [3:0]   fill_q;
	logic [4:0]   n_q;
	logic         full_q;

	logic [1:0]   kind_q;
	logic [127:0] odata_q;
	logic [4:0]   ovb_q;
	logic         ok_q, last_q;

	logic [127:0] blk_in;
	logic [4:0]   nin, aad_n, pl_n, tlen;
	logic [255:0] merged;
	logic [4:0]   total;
	logic [127:0] aes_din, aes_dout;
	logic [3:0]   rk_idx;
	logic         aes_done;
	logic [127:0] kx_prev;
	logic [31:0]  kx_t, kx_tt, n0, n1, n2, n3;
	logic [7:0]   b0_flags;
	logic         diff_zero;

	assign blk_in = {block_high, block_low};
	assign nin    = (valid_bytes > 5'd16) ? 5'd16 : valid_bytes;
	assign aad_n  = (aad_left_q < {27'd0, nin}) ? aad_left_q[4:0] : nin;
	assign pl_n   = (pl_left_q < {19'd0, nin}) ? pl_left_q[4:0] : nin;
	assign tlen   = tag_size_q ? 5'd16 : 5'd8;

	// The new bytes land right behind the bytes already buffered.
	assign merged = {buf_q, 128'd0} |
		({blk_in & byte_mask(aad_n), 128'd0} >> {fill_q, 3'b000});
	assign total  = {1'b0, fill_q} + aad_n;

	assign diff_zero = (((mac_q ^ mask_q ^ blk_in) & byte_mask(tlen)) == 128'd0);
	assign b0_flags  = ((aad_left_q != 32'd0) ? B0_ADATA_FLAG : 8'h00) |
		(tag_size_q ? 8'h38 : 8'h18) | CTR_FLAGS;

	// Key schedule: four words per step, window holds the last eight words.
	assign kx_prev = nk8_q ? win_q[255:128] : win_q[127:0];
	assign kx_t    = win_q[31:0];
	always_comb begin
		if (!nk8_q || !kx_idx_q[0]) begin
			kx_tt = {SBOX[kx_t[23:16]] ^ rcon(nk8_q ? {1'b0, kx_idx_q[3:1]} : kx_idx_q),
				SBOX[kx_t[15:8]], SBOX[kx_t[7:0]], SBOX[kx_t[31:24]]};
		end else begin
			kx_tt = {SBOX[kx_t[31:24]], SBOX[kx_t[23:16]],
				SBOX[kx_t[15:8]], SBOX[kx_t[7:0]]};
		end
		n0 = kx_prev[127:96] ^ kx_tt;
		n1 = kx_prev[95:64] ^ n0;
		n2 = kx_prev[63:32] ^ n1;
		n3 = kx_prev[31:0] ^ n2;
	end

	always_comb begin
		unique case (cmd.aes_src)
			SRC_B0:   aes_din = {b0_flags, nonce_q, pl_left_q};
			SRC_A0:   aes_din = {CTR_FLAGS, nonce_q, 24'd0};
			SRC_AAD:  aes_din = mac_q ^ blk_q;
			SRC_TAIL: aes_din = mac_q ^ buf_q;
			SRC_CTR:  aes_din = {CTR_FLAGS, nonce_q, ctr_q};
			SRC_PMAC: aes_din = mac_q ^ (dir_q ? res_q : blk_q);
			default:  aes_din = '0;
		endcase
	end

	ccm_aes_core u_aes (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (cmd.aes_go),
		.din    (aes_din),
		.nr     (nr_q),
		.rk     (rk_q[rk_idx]),
		.rk_idx (rk_idx),
		.done   (aes_done),
		.dout   (aes_dout)
	);

	always_comb begin
		sts.kx_done       = (kx_idx_q == nr_q);
		sts.aes_done      = aes_done;
		sts.aad_in_zero   = (aad_n == 5'd0);
		sts.pl_in_zero    = (pl_n == 5'd0);
		sts.aad_full      = full_q;
		sts.aad_left_zero = (aad_left_q == 32'd0);
		sts.fill_zero     = (fill_q == 4'd0);
		sts.pl_left_zero  = (pl_left_q == 24'd0);
		sts.decrypt       = dir_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q     <= '0;
			key1_q     <= '0;
			key2_q     <= '0;
			key3_q     <= '0;
			key_size_q <= 1'b0;
			tag_size_q <= 1'b1;
			dir_q      <= 1'b0;
			verify_q   <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_KEY0:      key0_q     <= cfg_data;
				CFG_KEY1:      key1_q     <= cfg_data;
				CFG_KEY2:      key2_q     <= cfg_data;
				CFG_KEY3:      key3_q     <= cfg_data;
				CFG_KEY_SIZE:  key_size_q <= cfg_data[0];
				CFG_TAG_SIZE:  tag_size_q <= cfg_data[0];
				CFG_DIRECTION: dir_q      <= cfg_data[0];
				CFG_VERIFY:    verify_q   <= cfg_data[0];
				default:       ;
			endcase
		end
	end

	// Round keys have no reset; each start request and its key schedule rewrite them.
	always_ff @(posedge clk) begin
		if (cmd.start_msg) begin
			rk_q[0] <= {key0_q, key1_q};
			if (key_size_q) begin
				rk_q[1] <= {key2_q, key3_q};
				win_q   <= {key0_q, key1_q, key2_q, key3_q};
			end else begin
				win_q   <= {128'd0, key0_q, key1_q};
			end
		end else if (cmd.kx_step) begin
			rk_q[kx_idx_q] <= {n0, n1, n2, n3};
			win_q          <= {win_q[127:0], n0, n1, n2, n3};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kx_idx_q   <= 4'd0;
			nr_q       <= NR_AES128;
			nk8_q      <= 1'b0;
			mac_q      <= '0;
			mask_q     <= '0;
			buf_q      <= '0;
			blk_q      <= '0;
			res_q      <= '0;
			nonce_q    <= '0;
			ctr_q      <= '0;
			pl_left_q  <= '0;
			aad_left_q <= '0;
			fill_q     <= '0;
			n_q        <= '0;
			full_q     <= 1'b0;
			kind_q     <= KIND_PAYLOAD;
			odata_q    <= '0;
			ovb_q      <= '0;
			ok_q       <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			if (cmd.start_msg) begin
				nonce_q    <= {nonce_high, nonce_low};
				pl_left_q  <= payload_length;
				aad_left_q <= aad_length;
				ctr_q      <= 24'd1;
				nk8_q      <= key_size_q;
				nr_q       <= key_size_q ? NR_AES256 : NR_AES128;
				kx_idx_q   <= key_size_q ? 4'd2 : 4'd1;
				if (aad_length == 32'd0) begin
					buf_q  <= '0;
					fill_q <= 4'd0;
				end else if (aad_length < AAD_SHORT_LIMIT) begin
					buf_q  <= {aad_length[15:0], 112'd0};
					fill_q <= 4'd2;
				end else begin
					buf_q  <= {AAD_LONG_MARK, aad_length, 80'd0};
					fill_q <= 4'd6;
				end
			end
			if (cmd.kx_step) begin
				kx_idx_q <= kx_idx_q + 4'd1;
			end
			if (cmd.latch_aad) begin
				aad_left_q <= aad_left_q - {27'd0, aad_n};
				full_q     <= total[4];
				if (total[4]) begin
					blk_q  <= merged[255:128];
					buf_q  <= merged[127:0];
				end else begin
					buf_q  <= merged[255:128];
				end
				fill_q <= total[3:0];
			end
			if (cmd.latch_pl) begin
				blk_q     <= blk_in & byte_mask(pl_n);
				n_q       <= pl_n;
				pl_left_q <= pl_left_q - {19'd0, pl_n};
			end
			if (cmd.clr_buf) begin
				buf_q  <= '0;
				fill_q <= 4'd0;
			end
			unique case (cmd.aes_dst)
				DST_MAC:  mac_q  <= aes_dout;
				DST_MASK: mask_q <= aes_dout;
				DST_CTR: begin
					res_q <= (blk_q ^ aes_dout) & byte_mask(n_q);
					ctr_q <= ctr_q + 24'd1;
				end
				default: ;
			endcase
			unique case (cmd.out_sel)
				OSEL_CHUNK: begin
					kind_q  <= KIND_PAYLOAD;
					odata_q <= res_q;
					ovb_q   <= n_q;
					ok_q    <= 1'b0;
					last_q  <= 1'b0;
				end
				OSEL_TAG: begin
					kind_q  <= KIND_TAG;
					odata_q <= (mac_q ^ mask_q) & byte_mask(tlen);
					ovb_q   <= tlen;
					ok_q    <= 1'b0;
					last_q  <= 1'b1;
				end
				OSEL_STAT: begin
					kind_q  <= KIND_STATUS;
					odata_q <= '0;
					ovb_q   <= 5'd0;
					ok_q    <= !verify_q || diff_zero;
					last_q  <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign result_kind     = kind_q;
	assign out_high        = odata_q[127:64];
	assign out_low         = odata_q[63:0];
	assign out_valid_bytes = ovb_q;
	assign auth_ok         = ok_q;
	assign last            = last_q;

endmodule

`default_nettype wire

### sv/ccm_ctrl.sv
`default_nettype none

// Message sequencer: walks each request through key schedule, AES passes and
// result hand-off, and tracks the message phase.
module ccm_ctrl
	import ccm_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] mode,
	output logic            out_valid,
	input  wire logic       out_ready,
	output cmd_t            cmd,
	input  wire sts_t       sts
);

	state_t state_q, state_nxt;
	phase_t phase_q, phase_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_IDLE;
		end else begin
			state_q <= state_nxt;
			phase_q <= phase_nxt;
		end
	end

	always_comb begin
		state_nxt   = state_q;
		phase_nxt   = phase_q;
		cmd         = '0;
		cmd.aes_src = SRC_B0;
		cmd.aes_dst = DST_NONE;
		cmd.out_sel = OSEL_NONE;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (mode_t'(mode))
						MODE_START: begin
							cmd.start_msg = 1'b1;
							state_nxt     = ST_KEYX;
						end
						MODE_AAD: begin
							if (phase_q == PH_AAD && !sts.aad_in_zero) begin
								cmd.latch_aad = 1'b1;
								state_nxt     = ST_AAD_CHK;
							end
						end
						MODE_PL: begin
							if (phase_q == PH_PAYLOAD && !sts.pl_in_zero) begin
								cmd.latch_pl = 1'b1;
								cmd.aes_go   = 1'b1;
								cmd.aes_src  = SRC_CTR;
								state_nxt    = ST_CTR;
							end
						end
						MODE_TAG: begin
							if (phase_q == PH_TAG) begin
								cmd.out_sel = OSEL_STAT;
								phase_nxt   = PH_IDLE;
								state_nxt   = ST_OUT_STAT;
							end
						end
						default: ;
					endcase
				end
			end
			ST_KEYX: begin
				cmd.kx_step = 1'b1;
				if (sts.kx_done) begin
					cmd.aes_go  = 1'b1;
					cmd.aes_src = SRC_B0;
					state_nxt   = ST_B0;
				end
			end
			ST_B0: begin
				if (sts.aes_done) begin
					cmd.aes_dst = DST_MAC;
					cmd.aes_go  = 1'b1;
					cmd.aes_src = SRC_A0;
					state_nxt   = ST_A0;
				end
			end
			ST_A0: begin
				if (sts.aes_done) begin
					cmd.aes_dst = DST_MASK;
					if (sts.aad_left_zero) begin
						state_nxt = ST_ENTER;
					end else begin
						phase_nxt = PH_AAD;
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_AAD_CHK: begin
				if (sts.aad_full) begin
					cmd.aes_go  = 1'b1;
					cmd.aes_src = SRC_AAD;
					state_nxt   = ST_AAD_BLK;
				end else begin
					state_nxt = ST_AAD_END;
				end
			end
			ST_AAD_BLK: begin
				if (sts.aes_done) begin
					cmd.aes_dst = DST_MAC;
					state_nxt   = ST_AAD_END;
				end
			end
			ST_AAD_END: begin
				priority if (sts.aad_left_zero && !sts.fill_zero) begin
					cmd.aes_go  = 1'b1;
					cmd.aes_src = SRC_TAIL;
					state_nxt   = ST_AAD_TAIL;
				end else if (sts.aad_left_zero) begin
					state_nxt = ST_ENTER;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_AAD_TAIL: begin
				if (sts.aes_done) begin
					cmd.aes_dst = DST_MAC;
					cmd.clr_buf = 1'b1;
					state_nxt   = ST_ENTER;
				end
			end
			ST_ENTER: begin
				priority if (!sts.pl_left_zero) begin
					phase_nxt = PH_PAYLOAD;
					state_nxt = ST_IDLE;
				end else if (!sts.decrypt) begin
					cmd.out_sel = OSEL_TAG;
					phase_nxt   = PH_IDLE;
					state_nxt   = ST_OUT_TAG;
				end else begin
					phase_nxt = PH_TAG;
					state_nxt = ST_IDLE;
				end
			end
			ST_CTR: begin
				if (sts.aes_done) begin
					cmd.aes_dst = DST_CTR;
					state_nxt   = ST_PGO;
				end
			end
			ST_PGO: begin
				cmd.aes_go  = 1'b1;
				cmd.aes_src = SRC_PMAC;
				state_nxt   = ST_PMAC;
			end
			ST_PMAC: begin
				if (sts.aes_done) begin
					cmd.aes_dst = DST_MAC;
					cmd.out_sel = OSEL_CHUNK;
					state_nxt   = ST_OUT_CHUNK;
				end
			end
			ST_OUT_CHUNK: begin
				out_valid = 1'b1;
				if (out_ready) begin
					priority if (!sts.pl_left_zero) begin
						state_nxt = ST_IDLE;
					end else if (!sts.decrypt) begin
						cmd.out_sel = OSEL_TAG;
						phase_nxt   = PH_IDLE;
						state_nxt   = ST_OUT_TAG;
					end else begin
						phase_nxt = PH_TAG;
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_OUT_TAG, ST_OUT_STAT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

endmodule

`default_nettype wire

### sv/aes_ccm_aead_engine.sv
// Sequence: a start request runs the key schedule (AES-128 or AES-256) and then two AES
// passes before the next request is taken.
// A payload chunk shows its result after a CTR pass, the ST_PGO state that starts the MAC
// pass, and the MAC pass; AAD takes 0 to 2 passes.
// Throughput is one request at a time, set by the single iterative AES round unit.
// Reset (arst_n low) returns the sequencer to idle and the registers to defaults;
`default_nettype none

// The round key store is not reset and is rewritten by each start request's key schedule.
// AES-CCM engine with a 12-byte nonce. Requests on the input channel are
// handled one at a time by the sequencer in ccm_ctrl, which steers the
// datapath: the key schedule, one shared AES round unit that serves the
// CBC-MAC chain and the counter-mode keystream in turn, the realignment of
// associated data behind its length prefix, and the result register.
// A payload request returns its processed chunk; when it closes an encrypt
// message, the masked tag follows as a second result. A tag request in a
// decrypt message returns the verify status.
module aes_ccm_aead_engine
	import ccm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  mode,
	input  wire logic [63:0] nonce_high,
	input  wire logic [31:0] nonce_low,
	input  wire logic [23:0] payload_length,
	input  wire logic [31:0] aad_length,
	input  wire logic [63:0] block_high,
	input  wire logic [63:0] block_low,
	input  wire logic [4:0]  valid_bytes,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic      [1:0]  result_kind,
	output logic      [63:0] out_high,
	output logic      [63:0] out_low,
	output logic      [4:0]  out_valid_bytes,
	output logic             auth_ok,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// Register writes must arrive only while the engine is idle; the engine does not enforce it.
	assign cfg_ready = 1'b1;

	ccm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	ccm_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.cfg_we          (cfg_valid),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.nonce_high      (nonce_high),
		.nonce_low       (nonce_low),
		.payload_length  (payload_length),
		.aad_length      (aad_length),
		.block_high      (block_high),
		.block_low       (block_low),
		.valid_bytes     (valid_bytes),
		.result_kind     (result_kind),
		.out_high        (out_high),
		.out_low         (out_low),
		.out_valid_bytes (out_valid_bytes),
		.auth_ok         (auth_ok),
		.last            (last)
	);

endmodule

`default_nettype wire

### sv/ccm_checker.sv
`default_nettype none

module ccm_checker
	import ccm_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [1:0]  result_kind,
	input wire logic [63:0] out_high,
	input wire logic [63:0] out_low,
	input wire logic [4:0]  out_valid_bytes,
	input wire logic        auth_ok,
	input wire logic        last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_high) && $stable(out_low)
			&& $stable(result_kind))
		else $error("result changed while stalled");

	a_status_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_STATUS |->
			out_high == 64'd0 && out_low == 64'd0 && out_valid_bytes == 5'd0 && last)
		else $error("verify status carries data");

	a_tag_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_TAG |->
			(out_valid_bytes == 5'd8 || out_valid_bytes == 5'd16) && last && !auth_ok)
		else $error("bad tag result");

	a_chunk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == KIND_PAYLOAD |->
			out_valid_bytes != 5'd0 && out_valid_bytes <= 5'd16 && !last && !auth_ok)
		else $error("bad payload result");

endmodule

bind aes_ccm_aead_engine ccm_checker u_ccm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.result_kind     (result_kind),
	.out_high        (out_high),
	.out_low         (out_low),
	.out_valid_bytes (out_valid_bytes),
	.auth_ok         (auth_ok),
	.last            (last)
);

`default_nettype wire
